### src/wgm_pkg.sv
// Shared definitions for the wildcard glob matcher: item kinds, special
// pattern bytes and the default pattern capacity. No dependencies.
`default_nettype none

package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [7:0] CH_ANY = 8'd63;  // '?'
    localparam logic [7:0] CH_RUN = 8'd42;  // '*'

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PAT   = 2'd1,
        KIND_NAME  = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

endpackage

`default_nettype wire

### src/wildcard_glob_matcher_core.sv
// Wildcard glob matcher top level: pattern registers, live-position vector
// with star closure, and the result register. Depends on wgm_pkg.
`default_nettype none

// Channel   Dir  Payload                                     Transfer
// s_axis    in   tuser[1:0] kind, tdata[7:0] byte_value       tvalid & tready
// m_axis    out  tdata[0] matched, tdata[1] pattern_too_long  tvalid & tready
//
// One input transfer per cycle; every item is fully processed in the cycle it
// is taken. An end-of-name item shows its result in the result register on
// the next cycle. The input side stalls only while that register holds a
// result that the output side has not taken. The match update is one compare
// per pattern position plus a ceil(log2(PATTERN_MAX+1))-level prefix network that
// spreads live bits across runs of stars. Reset empties the pattern and
// clears the overflow flag; the pattern bytes themselves are not cleared.
module wildcard_glob_matcher_core
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] byte_value
    input  wire  [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int LEVELS = $clog2(PATTERN_MAX + 1);

    // Pattern storage: one byte per position plus a thermometer of
    // positions below the stored length.
    logic [7:0]             r_pat [PATTERN_MAX];
    logic [7:0]             n_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_inlen, n_inlen;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic [PATTERN_MAX:0]   r_live, n_live;

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_data, n_out_data;

    logic       in_xfer;
    t_kind      kind;
    logic [7:0] in_byte;
    logic       byte_nz;
    logic       pat_wr;

    // Star and match terms, and the seed vector handed to the closure.
    logic [PATTERN_MAX-1:0] star_cur, step_match, star_nxt;
    logic [PATTERN_MAX:0]   seed, closed;

    assign kind    = t_kind'(s_axis_tuser);
    assign in_byte = s_axis_tdata;
    assign byte_nz = (in_byte != 8'd0);

    // The result register parts the two sides; take a new item whenever it
    // is empty or draining this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign pat_wr = in_xfer && (kind == KIND_PAT) && byte_nz
                    && (r_len < LEN_W'(PATTERN_MAX));

    // Next pattern contents and length.
    always_comb begin
        n_len   = r_len;
        n_inlen = r_inlen;
        n_ovf   = r_ovf;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            n_pat[p] = r_pat[p];
            if (pat_wr && (r_len == LEN_W'(p))) begin
                n_pat[p]   = in_byte;
                n_inlen[p] = 1'b1;
            end
        end
        if (pat_wr) begin
            n_len = r_len + LEN_W'(1);
        end
        if (in_xfer) begin
            unique case (kind)
                KIND_CLEAR: begin
                    n_len   = '0;
                    n_inlen = '0;
                    n_ovf   = 1'b0;
                end
                KIND_PAT: begin
                    if (byte_nz && !pat_wr) begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Step the live set by one name byte: a star keeps its position live,
    // a '?' or an equal byte moves it one place on.
    always_comb begin
        for (int p = 0; p < PATTERN_MAX; p++) begin
            star_cur[p]   = r_inlen[p] && (r_pat[p] == CH_RUN);
            step_match[p] = r_inlen[p] && r_live[p] && !star_cur[p]
                            && ((r_pat[p] == CH_ANY) || (r_pat[p] == in_byte));
            star_nxt[p]   = n_inlen[p] && (n_pat[p] == CH_RUN);
        end
    end

    // Pick the seed: an advanced set for a name byte, position zero alone on
    // a restart, the present set when nothing changes.
    always_comb begin
        seed = r_live;
        if (in_xfer) begin
            unique case (kind)
                KIND_NAME: begin
                    if (byte_nz) begin
                        seed = {1'b0, r_live[PATTERN_MAX-1:0] & star_cur}
                               | {step_match, 1'b0};
                    end
                end
                KIND_PAT: begin
                    if (byte_nz) begin
                        seed = (PATTERN_MAX + 1)'(1);
                    end
                end
                default: begin
                    seed = (PATTERN_MAX + 1)'(1);
                end
            endcase
        end
    end

    // Star closure as a prefix network: position q is live if some live
    // position at or below it reaches q across stars only.
    always_comb begin
        logic [PATTERN_MAX:0] g, pr, g_prev, pr_prev;
        int d;
        g  = seed;
        pr = {star_nxt, 1'b0};
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            d       = 1 << lvl;
            g_prev  = g;
            pr_prev = pr;
            for (int q = 0; q <= PATTERN_MAX; q++) begin
                if (q >= d) begin
                    g[q]  = g_prev[q] | (pr_prev[q] & g_prev[q-d]);
                    pr[q] = pr_prev[q] & pr_prev[q-d];
                end else begin
                    pr[q] = 1'b0;
                end
            end
        end
        closed = g;
    end

    assign n_live = closed;

    // Result register: load on an end-of-name item, drop once taken.
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        if (in_xfer && (kind == KIND_END)) begin
            n_out_valid = 1'b1;
            n_out_data  = {r_ovf, r_live[r_len] && !r_ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_inlen     <= '0;
            r_ovf       <= 1'b0;
            r_live      <= (PATTERN_MAX + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_inlen     <= n_inlen;
            r_ovf       <= n_ovf;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            r_pat[p] <= n_pat[p];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_data};

endmodule

`default_nettype wire

### src/wgm_checker.sv
// Port-level checker for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg.
`default_nettype none

module wgm_checker
    import wgm_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       s_axis_tvalid,
    input wire       s_axis_tready,
    input wire [7:0] s_axis_tdata,
    input wire [1:0] s_axis_tuser,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata
);

    logic end_xfer;
    assign end_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_END);

    // An accepted end-of-name item shows its result on the next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_xfer |=> m_axis_tvalid)
        else $error("no result after end-of-name transfer");

    // A fresh result only ever follows an end-of-name transfer.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(end_xfer))
        else $error("result without end-of-name transfer");

    // An overflowed pattern never reports a match.
    a_overflow_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("match reported with overflowed pattern");

    // A stalled result holds its data.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
